// ===== rtl/ddae_pkg.sv =====
// ----------------------------------------------------------------------------
// ddae_pkg
// Shared widths and constants for the decimal ASCII digit emitter.
// ----------------------------------------------------------------------------
package ddae_pkg;

  localparam int VALUE_BITS = 31;

  function automatic int digits_of(input int bits);
    longint unsigned v;
    int              n;
    v = (longint'(1) << bits) - 1;
    n = 0;
    do begin
      v = v / 10;
      n++;
    end while (v != 0);
    return n;
  endfunction

  localparam int NUM_DIGITS = digits_of(VALUE_BITS);
  localparam int BCD_BITS   = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

endpackage

// ===== rtl/decimal_ascii_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// decimal_ascii_digit_emitter
// Converts one unsigned binary value to decimal and emits its ASCII digits,
// most significant first, with a flag on the last digit.
//
//   port group        dir   handshake
//   start_i/value_i   in    taken when start_i & !busy_o
//   digit_*_o         out   each digit marked by digit_valid_o
//
// Conversion runs the shared shift-and-add-3 step once per bit of value_i
// (VALUE_BITS, 31 by default), then visits each BCD digit position in turn
// (NUM_DIGITS, 10 by default), leading zeros skipped silently.
// Reset clears the sequencer and the output strobe.
// Digits cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module decimal_ascii_digit_emitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ddae_pkg::VALUE_BITS-1:0] value_i,
  output logic                            busy_o,
  output logic                            digit_valid_o,
  output logic [5:0]                      digit_char_o,
  output logic                            last_digit_o
);

  ddae_pkg::state_e                  state_q, state_d;
  logic [ddae_pkg::VALUE_BITS-1:0]   shift_q, shift_d;
  logic [ddae_pkg::BCD_BITS-1:0]     bcd_q, bcd_d, bcd_step;
  logic [ddae_pkg::BIT_CNT_W-1:0]    bit_cnt_q, bit_cnt_d;
  logic [ddae_pkg::DIG_IDX_W-1:0]    dig_idx_q, dig_idx_d;
  logic                              started_q, started_d;
  logic                              valid_q, valid_d;
  logic [5:0]                        char_q, char_d;
  logic                              last_q, last_d;
  logic [3:0]                        top_digit;
  logic                              is_last;

  ddae_dabble u_dabble (
    .bcd_i (bcd_q),
    .bit_i (shift_q[ddae_pkg::VALUE_BITS-1]),
    .bcd_o (bcd_step)
  );

  assign top_digit = bcd_q[ddae_pkg::BCD_BITS-1 -: 4];
  assign is_last   = (dig_idx_q == '0);

  always_comb begin
    state_d   = state_q;
    shift_d   = shift_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_idx_d = dig_idx_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    case (state_q)
      ddae_pkg::ST_IDLE: begin
        if (start_i) begin
          shift_d   = value_i;
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = ddae_pkg::ST_CONV;
        end
      end
      ddae_pkg::ST_CONV: begin
        bcd_d     = bcd_step;
        shift_d   = shift_q << 1;
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == ddae_pkg::BIT_CNT_W'(ddae_pkg::VALUE_BITS - 1)) begin
          dig_idx_d = ddae_pkg::DIG_IDX_W'(ddae_pkg::NUM_DIGITS - 1);
          started_d = 1'b0;
          state_d   = ddae_pkg::ST_EMIT;
        end
      end
      ddae_pkg::ST_EMIT: begin
        if (top_digit != 4'd0 || started_q || is_last) begin
          valid_d   = 1'b1;
          char_d    = ddae_pkg::ASCII_ZERO + {2'b00, top_digit};
          last_d    = is_last;
          started_d = 1'b1;
        end
        bcd_d     = bcd_q << 4;
        dig_idx_d = dig_idx_q - 1'b1;
        if (is_last) begin
          state_d = ddae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddae_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ddae_pkg::ST_IDLE;
      valid_q   <= 1'b0;
      bit_cnt_q <= '0;
      dig_idx_q <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      bit_cnt_q <= bit_cnt_d;
      dig_idx_q <= dig_idx_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign busy_o        = (state_q != ddae_pkg::ST_IDLE);
  assign digit_valid_o = valid_q;
  assign digit_char_o  = char_q;
  assign last_digit_o  = last_q;

endmodule

// ===== rtl/ddae_dabble.sv =====
// ----------------------------------------------------------------------------
// ddae_dabble
// One shift-and-add-3 step: adjust every BCD digit, shift in one binary bit.
// ----------------------------------------------------------------------------
module ddae_dabble (
  input  logic [ddae_pkg::BCD_BITS-1:0] bcd_i,
  input  logic                          bit_i,
  output logic [ddae_pkg::BCD_BITS-1:0] bcd_o
);

  logic [ddae_pkg::BCD_BITS-1:0] adj;

  always_comb begin
    for (int i = 0; i < ddae_pkg::NUM_DIGITS; i++) begin
      if (bcd_i[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[ddae_pkg::BCD_BITS-2:0], bit_i};

endmodule

// ===== rtl/ddae_checker.sv =====
// ----------------------------------------------------------------------------
// ddae_checker
// Port-level checks for the decimal ASCII digit emitter.
// ----------------------------------------------------------------------------
module ddae_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       digit_valid_o,
  input logic [5:0] digit_char_o,
  input logic       last_digit_o
);

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> (digit_char_o >= 6'd48) && (digit_char_o <= 6'd57))
    else $error("digit character out of range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but block not busy");

  a_digit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o |-> $past(busy_o))
    else $error("digit outside a conversion");

  a_end_of_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> digit_valid_o && last_digit_o)
    else $error("run ended without last digit");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_valid_o && last_digit_o |=> !digit_valid_o)
    else $error("digit after last digit");

endmodule

bind decimal_ascii_digit_emitter ddae_checker u_ddae_checker (.*);

// ===== tb/decimal_ascii_digit_emitter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_ascii_digit_emitter_tb
// Sends non-negative values through the start/busy handshake and checks every
// emitted digit, character and end flag, in order against a queue of expected
// digits. A short table of edge values comes first, then random values spread
// over every digit count, with random gaps between items.
// ----------------------------------------------------------------------------
module decimal_ascii_digit_emitter_tb;

  localparam int         RANDOM_ITEMS = 260;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         MAX_GAP      = 8;
  localparam logic [5:0] CHAR_ZERO    = 6'd48;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } digit_t;

  typedef struct {
    logic [ddae_pkg::VALUE_BITS-1:0] value;
    string                           text;
  } vector_t;

  logic                            clk_i   = 1'b0;
  logic                            rst_ni  = 1'b0;
  logic                            start_i = 1'b0;
  logic [ddae_pkg::VALUE_BITS-1:0] value_i = '0;
  logic                            busy_o;
  logic                            digit_valid_o;
  logic [5:0]                      digit_char_o;
  logic                            last_digit_o;

  digit_t digit_q[$];
  int     mismatch_count = 0;
  int     idle_cycles    = 0;

  // an empty text means the row is checked against the predictor
  vector_t directed_vectors [18] = '{
    '{31'd0,          "0"},
    '{31'd1,          "1"},
    '{31'd9,          "9"},
    '{31'd10,         "10"},
    '{31'd99,         "99"},
    '{31'd100,        "100"},
    '{31'd1000,       "1000"},
    '{31'd10101,      ""},
    '{31'd999999999,  "999999999"},
    '{31'd1000000000, "1000000000"},
    '{31'd2147483647, "2147483647"},
    '{31'd1073741824, "1073741824"},
    '{31'd2147483646, ""},
    '{31'd1234567890, ""},
    '{31'd1431655765, ""},
    '{31'd715827882,  ""},
    '{31'd42,         ""},
    '{31'd100000,     ""}
  };

  decimal_ascii_digit_emitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_digit_o  (last_digit_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void predict_digits(input logic [ddae_pkg::VALUE_BITS-1:0] v);
    longint unsigned rest;
    digit_t          reversed[$];
    rest = v;
    do begin
      reversed.push_back(digit_t'{CHAR_ZERO + 6'(rest % 10), 1'b0});
      rest = rest / 10;
    end while (rest != 0);
    reversed[0].last = 1'b1;
    while (reversed.size() > 0) digit_q.push_back(reversed.pop_back());
  endfunction

  function automatic void push_text(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      digit_q.push_back(digit_t'{c[5:0], i == s.len() - 1});
    end
  endfunction

  task automatic send_value(input logic [ddae_pkg::VALUE_BITS-1:0] v, input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  always @(posedge clk_i) begin
    digit_t want;
    if (rst_ni && digit_valid_o) begin
      if (digit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected digit char=%0d last=%0b",
                                  digit_char_o, last_digit_o));
      end else begin
        want = digit_q.pop_front();
        if (digit_char_o !== want.ch)
          report_mismatch($sformatf("digit_char got %0d want %0d", digit_char_o, want.ch));
        if (last_digit_o !== want.last)
          report_mismatch($sformatf("last_digit got %0b want %0b", last_digit_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || digit_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("decimal_ascii_digit_emitter: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [ddae_pkg::VALUE_BITS-1:0] v;
    longint unsigned                 lo;
    longint unsigned                 hi;
    int                              gap;
    int                              ndig;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_vectors[i]) begin
      send_value(directed_vectors[i].value, $urandom_range(MAX_GAP, 0));
      if (directed_vectors[i].text != "") push_text(directed_vectors[i].text);
      else predict_digits(directed_vectors[i].value);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gap = (n % 50 < 12) ? 0 : $urandom_range(MAX_GAP, 0);
      if ($urandom_range(3, 0) == 0) begin
        v = ddae_pkg::VALUE_BITS'($urandom);
      end else begin
        ndig = $urandom_range(10, 1);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi   = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        v = ddae_pkg::VALUE_BITS'($urandom_range(32'(hi), 32'(lo)));
      end
      send_value(v, gap);
      predict_digits(v);
    end
    start_i <= 1'b0;

    while (digit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("decimal_ascii_digit_emitter: match");
    end else begin
      $display("decimal_ascii_digit_emitter: mismatch");
    end
    $finish;
  end

endmodule
